// ----- rtl/cns_pkg.sv -----
`timescale 1ns / 1ps

package cns_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int STATE_WIDTH_DEF  = 40;
    localparam int OUT_WIDTH        = 24;
    localparam int FRAC_BITS        = 24;
    localparam int SAMPLE_FRAC      = 12;
    localparam int COEF_W           = 25;
    localparam int AMP_W            = 16;
    localparam int MODE_W           = 2;
    localparam int CFG_INDEX_W      = 2;
    localparam int POLE_IDX_W       = 2;

    localparam logic [AMP_W-1:0] AMP_RESET = 16'd4096;

    // Filter and gain coefficients, unsigned Q.24
    localparam logic [COEF_W-1:0] C_SLOW_A = 25'd16737790;
    localparam logic [COEF_W-1:0] C_SLOW_B = 25'd1661716;
    localparam logic [COEF_W-1:0] C_MID_A  = 25'd16156459;
    localparam logic [COEF_W-1:0] C_MID_B  = 25'd4974720;
    localparam logic [COEF_W-1:0] C_FAST_A = 25'd9563013;
    localparam logic [COEF_W-1:0] C_FAST_B = 25'd17661229;
    localparam logic [COEF_W-1:0] C_DIRECT = 25'd3100430;
    localparam logic [COEF_W-1:0] C_TENTH  = 25'd1677722;
    localparam logic [COEF_W-1:0] C_DECAY  = 25'd16609444;

    typedef enum logic [MODE_W-1:0] {
        MODE_WHITE = 2'd0,
        MODE_PINK  = 2'd1,
        MODE_BROWN = 2'd2,
        MODE_OFF   = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODE = 2'd0,
        REG_AMP  = 2'd1
    } reg_index_t;

    typedef enum logic [1:0] {
        MA_SAMPLE,
        MA_LOW,
        MA_HIGH
    } mul_a_t;

    typedef enum logic [2:0] {
        SRC_SLOW,
        SRC_MID,
        SRC_FAST,
        SRC_LEVEL,
        SRC_TMP
    } src_t;

    typedef enum logic [3:0] {
        CF_SLOW_A,
        CF_SLOW_B,
        CF_MID_A,
        CF_MID_B,
        CF_FAST_A,
        CF_FAST_B,
        CF_DIRECT,
        CF_TENTH,
        CF_DECAY,
        CF_AMP
    } coef_t;

    typedef enum logic [2:0] {
        AO_HOLD,
        AO_CLEAR,
        AO_LOAD_R24,
        AO_LOAD_R12,
        AO_ADD,
        AO_ADD_R12,
        AO_LEVEL_R12
    } acc_op_t;

    typedef enum logic [2:0] {
        TO_HOLD,
        TO_CLEAR,
        TO_LOAD_PROD,
        TO_ADD_POLE,
        TO_ADD_R12
    } tmp_op_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_SLOW,
        WB_MID,
        WB_FAST,
        WB_LEVEL,
        WB_LEVEL_ADD
    } wb_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ZERO,
        ST_W_MUL,
        ST_W_RND,
        ST_P_LO,
        ST_P_HI,
        ST_P_IN,
        ST_P_RND,
        ST_P_WB,
        ST_P_DIR,
        ST_P_SUM,
        ST_P_GLO,
        ST_P_GHI,
        ST_P_GADD,
        ST_B_MUL,
        ST_B_HOLD,
        ST_B_ILO,
        ST_B_IHI,
        ST_B_IADD,
        ST_B_ACC,
        ST_B_DLO,
        ST_B_DHI,
        ST_B_DADD,
        ST_B_DWB,
        ST_B_RND,
        ST_OUT
    } state_t;

    typedef struct packed {
        mul_a_t  mul_a;
        src_t    src;
        coef_t   coef;
        acc_op_t acc_op;
        tmp_op_t tmp_op;
        wb_t     wb;
        logic    load_sample;
        logic    load_out;
    } dp_cmd_t;

    function automatic logic [COEF_W-1:0] coef_value(input coef_t sel);
        logic [COEF_W-1:0] c;
        unique case (sel)
            CF_SLOW_A: c = C_SLOW_A;
            CF_SLOW_B: c = C_SLOW_B;
            CF_MID_A:  c = C_MID_A;
            CF_MID_B:  c = C_MID_B;
            CF_FAST_A: c = C_FAST_A;
            CF_FAST_B: c = C_FAST_B;
            CF_DIRECT: c = C_DIRECT;
            CF_TENTH:  c = C_TENTH;
            CF_DECAY:  c = C_DECAY;
            default:   c = '0;
        endcase
        return c;
    endfunction

    function automatic src_t pole_src(input logic [POLE_IDX_W-1:0] idx);
        src_t s;
        unique case (idx)
            2'd0:    s = SRC_SLOW;
            2'd1:    s = SRC_MID;
            default: s = SRC_FAST;
        endcase
        return s;
    endfunction

    function automatic coef_t pole_coef_a(input logic [POLE_IDX_W-1:0] idx);
        coef_t c;
        unique case (idx)
            2'd0:    c = CF_SLOW_A;
            2'd1:    c = CF_MID_A;
            default: c = CF_FAST_A;
        endcase
        return c;
    endfunction

    function automatic coef_t pole_coef_b(input logic [POLE_IDX_W-1:0] idx);
        coef_t c;
        unique case (idx)
            2'd0:    c = CF_SLOW_B;
            2'd1:    c = CF_MID_B;
            default: c = CF_FAST_B;
        endcase
        return c;
    endfunction

    function automatic wb_t pole_wb(input logic [POLE_IDX_W-1:0] idx);
        wb_t w;
        unique case (idx)
            2'd0:    w = WB_SLOW;
            2'd1:    w = WB_MID;
            default: w = WB_FAST;
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/cns_datapath.sv -----
`timescale 1ns / 1ps

module cns_datapath #(
    parameter int SAMPLE_WIDTH = cns_pkg::SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH  = cns_pkg::STATE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cns_pkg::dp_cmd_t                     cmd,
    input  logic [cns_pkg::AMP_W-1:0]            amplitude,
    input  logic signed [SAMPLE_WIDTH-1:0]       white_sample,
    output logic signed [cns_pkg::OUT_WIDTH-1:0] noise_sample,
    output logic                                 clipped
);

    localparam int W_AMP   = SAMPLE_WIDTH + cns_pkg::AMP_W;
    localparam int ACC_W   = ((STATE_WIDTH > W_AMP) ? STATE_WIDTH : W_AMP) + 3;
    localparam int HI_W    = ACC_W - cns_pkg::FRAC_BITS;
    localparam int LO_A_W  = cns_pkg::FRAC_BITS + 1;
    localparam int A_W0    = (HI_W > LO_A_W) ? HI_W : LO_A_W;
    localparam int MUL_A_W = (A_W0 > SAMPLE_WIDTH) ? A_W0 : SAMPLE_WIDTH;
    localparam int MUL_B_W = cns_pkg::COEF_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int OUT_W   = cns_pkg::OUT_WIDTH;

    localparam logic signed [PROD_W-1:0] HALF_R24 = PROD_W'(1) <<< (cns_pkg::FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] HALF_P12 = PROD_W'(1) <<< (cns_pkg::SAMPLE_FRAC - 1);
    localparam logic signed [ACC_W-1:0]  HALF_A12 = ACC_W'(1) <<< (cns_pkg::SAMPLE_FRAC - 1);

    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic signed [STATE_WIDTH-1:0]  slow_reg, slow_next;
    logic signed [STATE_WIDTH-1:0]  mid_reg, mid_next;
    logic signed [STATE_WIDTH-1:0]  fast_reg, fast_next;
    logic signed [STATE_WIDTH-1:0]  level_reg, level_next;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;
    logic signed [ACC_W-1:0]        tmp_reg, tmp_next;
    logic signed [PROD_W-1:0]       prod_reg, prod_next;
    logic signed [OUT_W-1:0]        noise_reg, noise_next;
    logic                           clipped_reg, clipped_next;

    logic signed [ACC_W-1:0]        src_val;
    logic signed [MUL_A_W-1:0]      mul_a;
    logic signed [MUL_B_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]       prod_r24_full;
    logic signed [PROD_W-1:0]       prod_r12_full;
    logic signed [ACC_W-1:0]        prod_r24;
    logic signed [ACC_W-1:0]        prod_r12;
    logic signed [ACC_W-1:0]        prod_low;
    logic signed [ACC_W-1:0]        level_r12;
    logic signed [STATE_WIDTH-1:0]  acc_sat;
    logic signed [ACC_W-1:0]        level_sum;
    logic signed [STATE_WIDTH-1:0]  level_sum_sat;

    function automatic logic signed [STATE_WIDTH-1:0] sat_state(
        input logic signed [ACC_W-1:0] v
    );
        logic [ACC_W-STATE_WIDTH:0]     upper;
        logic signed [STATE_WIDTH-1:0]  r;
        upper = v[ACC_W-1:STATE_WIDTH-1];
        if ((&upper) || !(|upper))
            r = v[STATE_WIDTH-1:0];
        else if (v[ACC_W-1])
            r = {1'b1, {(STATE_WIDTH-1){1'b0}}};
        else
            r = {1'b0, {(STATE_WIDTH-1){1'b1}}};
        return r;
    endfunction

    // operand selection for the shared multiplier
    always_comb
    begin
        unique case (cmd.src)
            cns_pkg::SRC_SLOW:  src_val = ACC_W'(slow_reg);
            cns_pkg::SRC_MID:   src_val = ACC_W'(mid_reg);
            cns_pkg::SRC_FAST:  src_val = ACC_W'(fast_reg);
            cns_pkg::SRC_LEVEL: src_val = ACC_W'(level_reg);
            default:            src_val = tmp_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.mul_a)
            cns_pkg::MA_LOW:
                mul_a = MUL_A_W'({1'b0, src_val[cns_pkg::FRAC_BITS-1:0]});
            cns_pkg::MA_HIGH:
                mul_a = MUL_A_W'(signed'(src_val[ACC_W-1:cns_pkg::FRAC_BITS]));
            default:
                mul_a = MUL_A_W'(sample_reg);
        endcase
        if (cmd.coef == cns_pkg::CF_AMP)
            mul_b = MUL_B_W'({1'b0, amplitude});
        else
            mul_b = MUL_B_W'({1'b0, cns_pkg::coef_value(cmd.coef)});
    end

    assign prod_next = mul_a * mul_b;

    // round half up on the registered product
    assign prod_r24_full = (prod_reg + HALF_R24) >>> cns_pkg::FRAC_BITS;
    assign prod_r12_full = (prod_reg + HALF_P12) >>> cns_pkg::SAMPLE_FRAC;
    assign prod_r24      = signed'(prod_r24_full[ACC_W-1:0]);
    assign prod_r12      = signed'(prod_r12_full[ACC_W-1:0]);
    assign prod_low      = signed'(prod_reg[ACC_W-1:0]);
    assign level_r12     = (ACC_W'(level_reg) + HALF_A12) >>> cns_pkg::SAMPLE_FRAC;

    assign acc_sat       = sat_state(acc_reg);
    assign level_sum     = ACC_W'(level_reg) + acc_reg;
    assign level_sum_sat = sat_state(level_sum);

    always_comb
    begin
        unique case (cmd.acc_op)
            cns_pkg::AO_CLEAR:     acc_next = '0;
            cns_pkg::AO_LOAD_R24:  acc_next = prod_r24;
            cns_pkg::AO_LOAD_R12:  acc_next = prod_r12;
            cns_pkg::AO_ADD:       acc_next = acc_reg + prod_low;
            cns_pkg::AO_ADD_R12:   acc_next = acc_reg + prod_r12;
            cns_pkg::AO_LEVEL_R12: acc_next = level_r12;
            default:               acc_next = acc_reg;
        endcase

        unique case (cmd.tmp_op)
            cns_pkg::TO_CLEAR:     tmp_next = '0;
            cns_pkg::TO_LOAD_PROD: tmp_next = prod_low;
            cns_pkg::TO_ADD_POLE:  tmp_next = tmp_reg + ACC_W'(acc_sat);
            cns_pkg::TO_ADD_R12:   tmp_next = tmp_reg + prod_r12;
            default:               tmp_next = tmp_reg;
        endcase
    end

    always_comb
    begin
        slow_next  = slow_reg;
        mid_next   = mid_reg;
        fast_next  = fast_reg;
        level_next = level_reg;
        unique case (cmd.wb)
            cns_pkg::WB_SLOW:      slow_next  = acc_sat;
            cns_pkg::WB_MID:       mid_next   = acc_sat;
            cns_pkg::WB_FAST:      fast_next  = acc_sat;
            cns_pkg::WB_LEVEL:     level_next = acc_sat;
            cns_pkg::WB_LEVEL_ADD: level_next = level_sum_sat;
            default:               ;
        endcase
    end

    // saturate the finished value to the output range
    always_comb
    begin
        logic [ACC_W-OUT_W:0] upper;
        upper = acc_reg[ACC_W-1:OUT_W-1];
        noise_next   = noise_reg;
        clipped_next = clipped_reg;
        if (cmd.load_out)
        begin
            if ((&upper) || !(|upper))
            begin
                noise_next   = acc_reg[OUT_W-1:0];
                clipped_next = 1'b0;
            end
            else if (acc_reg[ACC_W-1])
            begin
                noise_next   = {1'b1, {(OUT_W-1){1'b0}}};
                clipped_next = 1'b1;
            end
            else
            begin
                noise_next   = {1'b0, {(OUT_W-1){1'b1}}};
                clipped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_reg  <= '0;
            mid_reg   <= '0;
            fast_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            slow_reg  <= slow_next;
            mid_reg   <= mid_next;
            fast_reg  <= fast_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
            sample_reg <= white_sample;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        tmp_reg     <= tmp_next;
        noise_reg   <= noise_next;
        clipped_reg <= clipped_next;
    end

    assign noise_sample = noise_reg;
    assign clipped      = clipped_reg;

endmodule

// ----- rtl/cns_ctrl.sv -----
`timescale 1ns / 1ps

module cns_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  cns_pkg::mode_t   mode,
    input  logic             sample_valid,
    output logic             sample_stall,
    output logic             noise_valid,
    input  logic             noise_stall,
    output cns_pkg::dp_cmd_t cmd
);

    cns_pkg::state_t                  state_reg, state_next;
    logic [cns_pkg::POLE_IDX_W-1:0]   pole_reg, pole_next;
    logic                             valid_reg, valid_next;
    logic                             out_room;

    assign out_room = !valid_reg || !noise_stall;

    always_comb
    begin
        state_next = state_reg;
        pole_next  = pole_reg;
        unique case (state_reg)
            cns_pkg::ST_IDLE:
            begin
                pole_next = '0;
                if (sample_valid)
                begin
                    unique case (mode)
                        cns_pkg::MODE_WHITE: state_next = cns_pkg::ST_W_MUL;
                        cns_pkg::MODE_PINK:  state_next = cns_pkg::ST_P_LO;
                        cns_pkg::MODE_BROWN: state_next = cns_pkg::ST_B_MUL;
                        default:             state_next = cns_pkg::ST_ZERO;
                    endcase
                end
            end
            cns_pkg::ST_ZERO:   state_next = cns_pkg::ST_OUT;
            cns_pkg::ST_W_MUL:  state_next = cns_pkg::ST_W_RND;
            cns_pkg::ST_W_RND:  state_next = cns_pkg::ST_OUT;
            cns_pkg::ST_P_LO:   state_next = cns_pkg::ST_P_HI;
            cns_pkg::ST_P_HI:   state_next = cns_pkg::ST_P_IN;
            cns_pkg::ST_P_IN:   state_next = cns_pkg::ST_P_RND;
            cns_pkg::ST_P_RND:  state_next = cns_pkg::ST_P_WB;
            cns_pkg::ST_P_WB:
            begin
                // advance to the next pole, or to the direct term after the fast one
                if (pole_reg == cns_pkg::POLE_IDX_W'(2))
                    state_next = cns_pkg::ST_P_DIR;
                else
                begin
                    state_next = cns_pkg::ST_P_LO;
                    pole_next  = pole_reg + cns_pkg::POLE_IDX_W'(1);
                end
            end
            cns_pkg::ST_P_DIR:  state_next = cns_pkg::ST_P_SUM;
            cns_pkg::ST_P_SUM:  state_next = cns_pkg::ST_P_GLO;
            cns_pkg::ST_P_GLO:  state_next = cns_pkg::ST_P_GHI;
            cns_pkg::ST_P_GHI:  state_next = cns_pkg::ST_P_GADD;
            cns_pkg::ST_P_GADD: state_next = cns_pkg::ST_OUT;
            cns_pkg::ST_B_MUL:  state_next = cns_pkg::ST_B_HOLD;
            cns_pkg::ST_B_HOLD: state_next = cns_pkg::ST_B_ILO;
            cns_pkg::ST_B_ILO:  state_next = cns_pkg::ST_B_IHI;
            cns_pkg::ST_B_IHI:  state_next = cns_pkg::ST_B_IADD;
            cns_pkg::ST_B_IADD: state_next = cns_pkg::ST_B_ACC;
            cns_pkg::ST_B_ACC:  state_next = cns_pkg::ST_B_DLO;
            cns_pkg::ST_B_DLO:  state_next = cns_pkg::ST_B_DHI;
            cns_pkg::ST_B_DHI:  state_next = cns_pkg::ST_B_DADD;
            cns_pkg::ST_B_DADD: state_next = cns_pkg::ST_B_DWB;
            cns_pkg::ST_B_DWB:  state_next = cns_pkg::ST_B_RND;
            cns_pkg::ST_B_RND:  state_next = cns_pkg::ST_OUT;
            cns_pkg::ST_OUT:
            begin
                if (out_room)
                    state_next = cns_pkg::ST_IDLE;
            end
            default:            state_next = cns_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.mul_a       = cns_pkg::MA_SAMPLE;
        cmd.src         = cns_pkg::pole_src(pole_reg);
        cmd.coef        = cns_pkg::CF_AMP;
        cmd.acc_op      = cns_pkg::AO_HOLD;
        cmd.tmp_op      = cns_pkg::TO_HOLD;
        cmd.wb          = cns_pkg::WB_NONE;
        cmd.load_sample = 1'b0;
        cmd.load_out    = 1'b0;
        sample_stall    = (state_reg != cns_pkg::ST_IDLE);
        unique case (state_reg)
            cns_pkg::ST_IDLE:
                cmd.load_sample = sample_valid;
            cns_pkg::ST_ZERO:
                cmd.acc_op = cns_pkg::AO_CLEAR;
            cns_pkg::ST_W_MUL:
                cmd.coef = cns_pkg::CF_AMP;
            cns_pkg::ST_W_RND:
                cmd.acc_op = cns_pkg::AO_LOAD_R12;
            cns_pkg::ST_P_LO:
            begin
                cmd.mul_a = cns_pkg::MA_LOW;
                cmd.coef  = cns_pkg::pole_coef_a(pole_reg);
                if (pole_reg == '0)
                    cmd.tmp_op = cns_pkg::TO_CLEAR;
            end
            cns_pkg::ST_P_HI:
            begin
                cmd.mul_a  = cns_pkg::MA_HIGH;
                cmd.coef   = cns_pkg::pole_coef_a(pole_reg);
                cmd.acc_op = cns_pkg::AO_LOAD_R24;
            end
            cns_pkg::ST_P_IN:
            begin
                cmd.coef   = cns_pkg::pole_coef_b(pole_reg);
                cmd.acc_op = cns_pkg::AO_ADD;
            end
            cns_pkg::ST_P_RND:
                cmd.acc_op = cns_pkg::AO_ADD_R12;
            cns_pkg::ST_P_WB:
            begin
                cmd.wb     = cns_pkg::pole_wb(pole_reg);
                cmd.tmp_op = cns_pkg::TO_ADD_POLE;
            end
            cns_pkg::ST_P_DIR:
                cmd.coef = cns_pkg::CF_DIRECT;
            cns_pkg::ST_P_SUM:
                cmd.tmp_op = cns_pkg::TO_ADD_R12;
            cns_pkg::ST_P_GLO:
            begin
                cmd.mul_a = cns_pkg::MA_LOW;
                cmd.src   = cns_pkg::SRC_TMP;
            end
            cns_pkg::ST_P_GHI:
            begin
                cmd.mul_a  = cns_pkg::MA_HIGH;
                cmd.src    = cns_pkg::SRC_TMP;
                cmd.acc_op = cns_pkg::AO_LOAD_R24;
            end
            cns_pkg::ST_P_GADD:
                cmd.acc_op = cns_pkg::AO_ADD;
            cns_pkg::ST_B_MUL:
                cmd.coef = cns_pkg::CF_AMP;
            cns_pkg::ST_B_HOLD:
                cmd.tmp_op = cns_pkg::TO_LOAD_PROD;
            cns_pkg::ST_B_ILO:
            begin
                cmd.mul_a = cns_pkg::MA_LOW;
                cmd.src   = cns_pkg::SRC_TMP;
                cmd.coef  = cns_pkg::CF_TENTH;
            end
            cns_pkg::ST_B_IHI:
            begin
                cmd.mul_a  = cns_pkg::MA_HIGH;
                cmd.src    = cns_pkg::SRC_TMP;
                cmd.coef   = cns_pkg::CF_TENTH;
                cmd.acc_op = cns_pkg::AO_LOAD_R24;
            end
            cns_pkg::ST_B_IADD:
                cmd.acc_op = cns_pkg::AO_ADD;
            cns_pkg::ST_B_ACC:
                cmd.wb = cns_pkg::WB_LEVEL_ADD;
            cns_pkg::ST_B_DLO:
            begin
                cmd.mul_a = cns_pkg::MA_LOW;
                cmd.src   = cns_pkg::SRC_LEVEL;
                cmd.coef  = cns_pkg::CF_DECAY;
            end
            cns_pkg::ST_B_DHI:
            begin
                cmd.mul_a  = cns_pkg::MA_HIGH;
                cmd.src    = cns_pkg::SRC_LEVEL;
                cmd.coef   = cns_pkg::CF_DECAY;
                cmd.acc_op = cns_pkg::AO_LOAD_R24;
            end
            cns_pkg::ST_B_DADD:
                cmd.acc_op = cns_pkg::AO_ADD;
            cns_pkg::ST_B_DWB:
                cmd.wb = cns_pkg::WB_LEVEL;
            cns_pkg::ST_B_RND:
                cmd.acc_op = cns_pkg::AO_LEVEL_R12;
            cns_pkg::ST_OUT:
                cmd.load_out = out_room;
            default:
                ;
        endcase
    end

    // hold the result until the consumer takes it
    always_comb
    begin
        if (cmd.load_out)
            valid_next = 1'b1;
        else if (valid_reg && !noise_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cns_pkg::ST_IDLE;
            pole_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pole_reg  <= pole_next;
            valid_reg <= valid_next;
        end
    end

    assign noise_valid = valid_reg;

endmodule

// ----- rtl/coloured_noise_shaper.sv -----
`timescale 1ns / 1ps

// Coloured noise shaper: takes one white Gaussian sample (signed, 12 fraction bits) per transfer
// and returns one white, pink or brown noise sample in signed Q11.12, saturated, with a clip
// flag. All products go through one shared multiplier under a sequencer, and state wider than
// 24 fraction bits is multiplied in two halves, so the time per sample depends on the mode: pink
// steps through each filter pole, then the direct term and the split gain product, and the
// unused mode 3 returns zero. The next sample is taken as soon as the sequencer is back in idle,
// even while the last result still waits in the output register; a result that is held waits
// in the final step until the output register frees. Mode and amplitude are written through the
// configuration port (index 0 mode, index 1 amplitude, other indices ignored); the user must
// write them only while no sample is in flight, which the block itself does not enforce.

module coloured_noise_shaper #(
    parameter int SAMPLE_WIDTH = cns_pkg::SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH  = cns_pkg::STATE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]       white_sample,
    output logic                                 noise_valid,
    input  logic                                 noise_stall,
    output logic signed [cns_pkg::OUT_WIDTH-1:0] noise_sample,
    output logic                                 clipped,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cns_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [cns_pkg::AMP_W-1:0]            cfg_data
);

    cns_pkg::mode_t              mode_reg, mode_next;
    logic [cns_pkg::AMP_W-1:0]   amp_reg, amp_next;
    cns_pkg::dp_cmd_t            cmd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        mode_next = mode_reg;
        amp_next  = amp_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == cns_pkg::REG_MODE)
                mode_next = cns_pkg::mode_t'(cfg_data[cns_pkg::MODE_W-1:0]);
            else if (cfg_index == cns_pkg::REG_AMP)
                amp_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= cns_pkg::MODE_WHITE;
            amp_reg  <= cns_pkg::AMP_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
            amp_reg  <= amp_next;
        end
    end

    cns_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode_reg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .noise_valid  (noise_valid),
        .noise_stall  (noise_stall),
        .cmd          (cmd)
    );

    cns_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STATE_WIDTH  (STATE_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .amplitude    (amp_reg),
        .white_sample (white_sample),
        .noise_sample (noise_sample),
        .clipped      (clipped)
    );

    // one sample in flight: a transfer closes the input until the result is produced
    a_busy_after_transfer: assert property (
        @(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> sample_stall
    ) else $error("input accepted again right after a transfer");

    // a new result only appears at the end of a sequence, never straight from idle
    a_result_from_sequence: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(noise_valid) |-> $past(sample_stall)
    ) else $error("result produced without a sequence in progress");

    // the clip flag only comes with a value at one end of the output range
    a_clip_at_rail: assert property (
        @(posedge clk) disable iff (!rst_n)
        (noise_valid && clipped) |->
            (noise_sample == {1'b0, {(cns_pkg::OUT_WIDTH-1){1'b1}}}) ||
            (noise_sample == {1'b1, {(cns_pkg::OUT_WIDTH-1){1'b0}}})
    ) else $error("clip flag set on an unsaturated value");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int SAMPLE_W    = 16;
    localparam int STATE_W     = 40;
    localparam int DATA_W      = cns_pkg::AMP_W;
    localparam int OUT_W       = cns_pkg::OUT_WIDTH;
    localparam int TARGET_RAND = 600;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 40;
    localparam int REPORT_MAX  = 10;

    // Q.24 filter and gain coefficients
    localparam logic [24:0] K_SLOW_A = 25'd16737790;
    localparam logic [24:0] K_SLOW_B = 25'd1661716;
    localparam logic [24:0] K_MID_A  = 25'd16156459;
    localparam logic [24:0] K_MID_B  = 25'd4974720;
    localparam logic [24:0] K_FAST_A = 25'd9563013;
    localparam logic [24:0] K_FAST_B = 25'd17661229;
    localparam logic [24:0] K_DIRECT = 25'd3100430;
    localparam logic [24:0] K_TENTH  = 25'd1677722;
    localparam logic [24:0] K_DECAY  = 25'd16609444;

    localparam logic [cns_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [cns_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef logic signed [95:0] wide_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] level;
        logic                    clip;
    } noise_t;

    typedef enum logic [1:0] {
        PAT_UNIFORM,
        PAT_GAUSS,
        PAT_DRIVE_HIGH,
        PAT_DRIVE_LOW
    } pattern_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                sample_valid = 1'b0;
    logic                                sample_stall;
    sample_t                             white_sample = '0;
    logic                                noise_valid;
    logic                                noise_stall = 1'b0;
    logic signed [OUT_W-1:0]             noise_sample;
    logic                                clipped;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [cns_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [DATA_W-1:0]                   cfg_data = '0;

    coloured_noise_shaper #(
        .SAMPLE_WIDTH (SAMPLE_W),
        .STATE_WIDTH  (STATE_W)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .white_sample (white_sample),
        .noise_valid  (noise_valid),
        .noise_stall  (noise_stall),
        .noise_sample (noise_sample),
        .clipped      (clipped),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // shaper state mirrored for prediction
    cns_pkg::mode_t mode_q  = cns_pkg::MODE_WHITE;
    logic [15:0]    amp_q   = 16'd4096;
    wide_t          slow_q  = '0;
    wide_t          mid_q   = '0;
    wide_t          fast_q  = '0;
    wide_t          level_q = '0;

    sample_t white_backlog[$];
    noise_t  noise_due[$];

    bit drv_calm = 1'b0;
    bit mon_calm = 1'b0;
    int send_gap = 0;
    int hold_left = 0;

    int samples_sent = 0;
    int results_seen = 0;
    int clips_seen = 0;
    int reg_writes = 0;
    int fault_count = 0;
    int unsigned cycle_count = 0;

    function automatic wide_t widen(input logic [24:0] c);
        return $signed({71'd0, c});
    endfunction

    // round half up, floor semantics on negatives
    function automatic wide_t round_shift(input wide_t v, input int s);
        return (v + (wide_t'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic wide_t clamp(input wide_t v, input int bits);
        wide_t top;
        top = (wide_t'(1) <<< (bits - 1)) - 1;
        if (v > top)
            return top;
        if (v < -top - 1)
            return -top - 1;
        return v;
    endfunction

    function automatic wide_t pole_next(input wide_t pole, input logic [24:0] a,
                                        input logic [24:0] b, input wide_t w);
        return clamp(round_shift(pole * widen(a), 24) + round_shift(w * widen(b), 12), STATE_W);
    endfunction

    function automatic noise_t shape_sample(input sample_t smp);
        wide_t  w;
        wide_t  gain;
        wide_t  acc;
        wide_t  res;
        wide_t  lim;
        noise_t out;
        w    = smp;
        gain = $signed({80'd0, amp_q});
        res  = '0;
        case (mode_q)
            cns_pkg::MODE_WHITE:
                res = round_shift(w * gain, 12);
            cns_pkg::MODE_PINK:
            begin
                slow_q = pole_next(slow_q, K_SLOW_A, K_SLOW_B, w);
                mid_q  = pole_next(mid_q, K_MID_A, K_MID_B, w);
                fast_q = pole_next(fast_q, K_FAST_A, K_FAST_B, w);
                acc    = slow_q + mid_q + fast_q + round_shift(w * widen(K_DIRECT), 12);
                res    = round_shift(acc * gain, 24);
            end
            cns_pkg::MODE_BROWN:
            begin
                acc     = round_shift(w * gain * widen(K_TENTH), 24);
                level_q = clamp(level_q + acc, STATE_W);
                level_q = clamp(round_shift(level_q * widen(K_DECAY), 24), STATE_W);
                res     = round_shift(level_q, 12);
            end
            default:
                res = '0;
        endcase
        lim       = clamp(res, OUT_W);
        out.clip  = (lim != res);
        out.level = lim[OUT_W-1:0];
        return out;
    endfunction

    task automatic flag_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_MAX)
            $display("[%0t] %s", $time, msg);
    endtask

    // sample driver
    always @(posedge clk)
    begin
        bit take;
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            take = sample_valid && !sample_stall;
            if (take)
            begin
                noise_due.insert(noise_due.size(), shape_sample(white_sample));
                samples_sent++;
                send_gap = drv_calm ? 0 : $urandom_range(0, 14);
            end
            if (take || !sample_valid)
            begin
                if (send_gap == 0 && white_backlog.size() != 0)
                begin
                    sample_valid <= 1'b1;
                    white_sample <= white_backlog.pop_front();
                end
                else
                begin
                    sample_valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap--;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        noise_t want;
        if (!rst_n)
        begin
            noise_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (noise_valid && !noise_stall)
            begin
                results_seen++;
                if (clipped)
                    clips_seen++;
                if (noise_due.size() == 0)
                begin
                    flag_fault($sformatf("unexpected result: noise_sample %0d clipped %0b",
                                         noise_sample, clipped));
                end
                else
                begin
                    want = noise_due.pop_front();
                    if (noise_sample !== want.level || clipped !== want.clip)
                        flag_fault($sformatf({"mismatch on result %0d: noise_sample exp %0d ",
                                              "got %0d, clipped exp %0b got %0b"},
                                             results_seen, want.level, noise_sample,
                                             want.clip, clipped));
                end
                hold_left = mon_calm ? 0 : $urandom_range(0, 14);
            end
            else if (hold_left > 0)
            begin
                hold_left--;
            end
            noise_stall <= (hold_left != 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [cns_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        // transfer took place at this edge
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == cns_pkg::REG_MODE)
            mode_q = cns_pkg::mode_t'(data[cns_pkg::MODE_W-1:0]);
        else if (idx == cns_pkg::REG_AMP)
            amp_q = data;
    endtask

    task automatic set_shape(input cns_pkg::mode_t m, input logic [DATA_W-1:0] gain);
        logic [DATA_W-1:0] word;
        // upper bits of a mode write carry junk
        word = DATA_W'($urandom);
        word[cns_pkg::MODE_W-1:0] = m;
        write_reg(cns_pkg::REG_MODE, word);
        write_reg(cns_pkg::REG_AMP, gain);
    endtask

    task automatic drain();
        while (white_backlog.size() != 0 || sample_valid || noise_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic queue_samples(input pattern_t pat, input int count);
        int v;
        for (int i = 0; i < count; i++)
        begin
            case (pat)
                PAT_UNIFORM:
                    v = $urandom;
                PAT_GAUSS:
                    v = $urandom_range(0, 8192) + $urandom_range(0, 8192)
                        + $urandom_range(0, 8192) + $urandom_range(0, 8192) - 16384;
                PAT_DRIVE_HIGH:
                    v = 32767 - $urandom_range(0, 63);
                default:
                    v = -32768 + $urandom_range(0, 63);
            endcase
            white_backlog.insert(white_backlog.size(), sample_t'(v));
        end
    endtask

    initial
    begin : stimulus
        int             planned;
        int             span;
        cns_pkg::mode_t m;
        logic [15:0]    gain;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: white at unity gain
        white_backlog = '{16'sd0, 16'sd32767, 16'sh8000, 16'sd1, -16'sd1};
        drain();

        // writes to unused indexes must leave the settings alone
        write_reg(REG_SPARE_LO, DATA_W'($urandom));
        write_reg(REG_SPARE_HI, DATA_W'($urandom));
        white_backlog = '{16'sd12345};
        drain();

        set_shape(cns_pkg::MODE_WHITE, 16'hFFFF);
        white_backlog = '{16'sd32767, 16'sh8000, 16'sd21845, -16'sd21846};
        drain();
        set_shape(cns_pkg::MODE_WHITE, 16'h0000);
        white_backlog = '{16'sd32767};
        drain();
        set_shape(cns_pkg::MODE_PINK, 16'h1000);
        white_backlog = '{16'sd32767, 16'sh8000, 16'sd0, 16'sd1234};
        drain();
        set_shape(cns_pkg::MODE_BROWN, 16'hFFFF);
        white_backlog = '{16'sd32767, 16'sh8000, 16'sd32767};
        drain();
        // unused mode: zero output, filter and level state held
        set_shape(cns_pkg::MODE_OFF, 16'hFFFF);
        white_backlog = '{16'sd32767, 16'sh8000};
        drain();
        set_shape(cns_pkg::MODE_PINK, 16'hFFFF);
        white_backlog = '{-16'sd5000};
        drain();

        // hold the pink input near full scale at full gain to push into saturation
        queue_samples(PAT_DRIVE_LOW, 110);
        drain();
        drv_calm = 1'b1;
        queue_samples(PAT_DRIVE_HIGH, 150);
        drain();
        planned = 260;

        while (planned < TARGET_RAND)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:    m = cns_pkg::MODE_WHITE;
                3, 4, 5, 6: m = cns_pkg::MODE_PINK;
                7, 8:       m = cns_pkg::MODE_BROWN;
                default:    m = cns_pkg::MODE_OFF;
            endcase
            case ($urandom_range(0, 5))
                0:       gain = 16'h0000;
                1:       gain = 16'hFFFF;
                2:       gain = 16'h1000;
                default: gain = DATA_W'($urandom);
            endcase
            drv_calm = ($urandom_range(0, 3) == 0);
            mon_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          DATA_W'($urandom));
            set_shape(m, gain);
            span = $urandom_range(20, 70);
            queue_samples(pattern_t'($urandom_range(0, 3)), span);
            drain();
            planned += span;
        end

        repeat (SETTLE) @(posedge clk);
        if (noise_due.size() != 0)
            flag_fault($sformatf("%0d results never arrived", noise_due.size()));

        $display("Sent %0d white samples across white, pink, brown and unused modes with %0d",
                 samples_sent, reg_writes);
        $display("register writes; %0d results checked, %0d saturated, %0d faults.",
                 results_seen, clips_seen, fault_count);
        if (fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
